// ===== rtl/core/kpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, byte codes and helpers for the keyboard packet decoder.
// ----------------------------------------------------------------------------
package kpd_pkg;

  // Header bytes seen in the idle phase
  localparam logic [7:0] HDR_JOY1 = 8'hFF;
  localparam logic [7:0] HDR_JOY0 = 8'hFE;
  localparam logic [7:0] HDR_MOUSE_LO = 8'hF8;
  localparam logic [7:0] HDR_MOUSE_HI = 8'hFB;

  // Cursor make codes
  localparam logic [7:0] KEY_UP = 8'd72;
  localparam logic [7:0] KEY_LEFT = 8'd75;
  localparam logic [7:0] KEY_RIGHT = 8'd77;
  localparam logic [7:0] KEY_DOWN = 8'd80;
  localparam logic [7:0] KEY_SPACE = 8'd57;

  // Cursor joystick bits
  localparam logic [7:0] CJ_UP = 8'd1;
  localparam logic [7:0] CJ_DOWN = 8'd2;
  localparam logic [7:0] CJ_LEFT = 8'd4;
  localparam logic [7:0] CJ_RIGHT = 8'd8;
  localparam logic [7:0] CJ_FIRE = 8'd128;

  // Decoded values, as shown on the result channel
  typedef struct packed {
    logic [7:0]         joystick0;
    logic [7:0]         joystick1;
    logic [7:0]         cursor_joystick;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic [1:0]         mouse_buttons;
    logic [7:0]         recent_key;
  } kpd_result_t;

  // Cursor joystick bit for a make code, zero when not a cursor key
  function automatic logic [7:0] cursor_bit(input logic [7:0] code);
    logic [7:0] bit_v;
    case (code)
      KEY_UP:    bit_v = CJ_UP;
      KEY_LEFT:  bit_v = CJ_LEFT;
      KEY_RIGHT: bit_v = CJ_RIGHT;
      KEY_DOWN:  bit_v = CJ_DOWN;
      KEY_SPACE: bit_v = CJ_FIRE;
      default:   bit_v = 8'd0;
    endcase
    return bit_v;
  endfunction

  // Sign-extend a packet byte to a 16-bit addend
  function automatic logic [15:0] byte_delta(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

// ===== rtl/core/kpd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_core
// Packet parser state and decoded registers; updates once per byte taken.
// ----------------------------------------------------------------------------
module kpd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_en,
  input  logic [7:0]           byte_in,
  output kpd_pkg::kpd_result_t res
);
  import kpd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_JOY0 = 3'd1,
    PH_JOY1 = 3'd2,
    PH_MDX  = 3'd3,
    PH_MDY  = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  kpd_result_t res_r, res_nxt;
  logic [7:0]  make_bit;
  logic [7:0]  brk_bit;

  assign make_bit = cursor_bit(byte_in);
  assign brk_bit  = byte_in[7] ? cursor_bit({1'b0, byte_in[6:0]}) : 8'd0;

  always_comb begin
    res_nxt   = res_r;
    phase_nxt = PH_IDLE;
    case (phase_r)
      PH_JOY1: res_nxt.joystick1 = byte_in;
      PH_JOY0: res_nxt.joystick0 = byte_in;
      PH_MDX: begin
        res_nxt.mouse_x = res_r.mouse_x + byte_delta(byte_in);
        phase_nxt       = PH_MDY;
      end
      PH_MDY: res_nxt.mouse_y = res_r.mouse_y + byte_delta(byte_in);
      default: begin
        if (byte_in == HDR_JOY1) begin
          phase_nxt = PH_JOY1;
        end else if (byte_in == HDR_JOY0) begin
          phase_nxt = PH_JOY0;
        end else if (byte_in inside {[HDR_MOUSE_LO:HDR_MOUSE_HI]}) begin
          res_nxt.mouse_buttons = byte_in[1:0];
          phase_nxt             = PH_MDX;
        end else if (make_bit != 8'd0) begin
          res_nxt.cursor_joystick = res_r.cursor_joystick | make_bit;
        end else if (brk_bit != 8'd0) begin
          res_nxt.cursor_joystick = res_r.cursor_joystick & ~brk_bit;
        end else begin
          res_nxt.recent_key = byte_in;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      res_r   <= '0;
    end else if (byte_en) begin
      phase_r <= phase_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

  // Header sequencing, and state held while no byte is taken
  a_joy1_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    byte_en && phase_r == PH_IDLE && byte_in == HDR_JOY1 |=> phase_r == PH_JOY1)
    else $error("joystick 1 header not followed by data phase");

  a_mdx_to_mdy: assert property (@(posedge clk) disable iff (!rst_n)
    byte_en && phase_r == PH_MDX |=> phase_r == PH_MDY)
    else $error("mouse dx not followed by dy phase");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !byte_en |=> $stable(res_r) && $stable(phase_r))
    else $error("decoder state moved without a byte");

endmodule

// ===== rtl/core/keyboard_packet_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_packet_decoder_top
// Byte-serial keyboard controller packet decoder with valid/stall channels.
// ----------------------------------------------------------------------------
// Usage notes:
//  - Input channel: one scan byte per word on in_scan_byte, taken at an edge
//    where in_valid is high and in_stall is low.
//  - Result channel: one word per input byte, carrying every decoded value
//    (both joysticks, cursor joystick, mouse position and buttons, most
//    recent key) as it stands after that byte. Taken where out_valid high,
//    out_stall low.
//  - Path: a taken byte passes the input register, then the decode updates
//    the result registers and out_valid rises; a stall on the result channel
//    can hold the byte in the input register between the two.
//  - Throughput: one byte per cycle while the result channel is not stalled;
//    the decode is a single short pass of compare, select and one 16-bit add
//    between the input register and the result registers.
//  - Stall: when the receiver stalls, the result word holds; one further byte
//    waits in the input register and in_stall rises only once that is full.
//  - Reset: rst_n (synchronous, active low) clears all decoded values to zero,
//    returns the parser to idle and empties both registers.
// ----------------------------------------------------------------------------
module keyboard_packet_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_scan_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_joystick0,
  output logic [7:0]         out_joystick1,
  output logic [7:0]         out_cursor_joystick,
  output logic signed [15:0] out_mouse_x,
  output logic signed [15:0] out_mouse_y,
  output logic [1:0]         out_mouse_buttons,
  output logic [7:0]         out_recent_key
);
  import kpd_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r, out_valid_nxt;
  logic        in_take;
  logic        s1_adv;
  kpd_result_t res;

  // The decode advances whenever the result register is free or being taken
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input word register, payload only
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_scan_byte;
    end
  end

  // Parser state doubles as the result register: it only moves on advance,
  // which needs the result slot free or its word being taken
  kpd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (s1_adv),
    .byte_in (s1_byte_r),
    .res     (res)
  );

  assign out_valid           = out_valid_r;
  assign out_joystick0       = res.joystick0;
  assign out_joystick1       = res.joystick1;
  assign out_cursor_joystick = res.cursor_joystick;
  assign out_mouse_x         = res.mouse_x;
  assign out_mouse_y         = res.mouse_y;
  assign out_mouse_buttons   = res.mouse_buttons;
  assign out_recent_key      = res.recent_key;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked word");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("decoded word not presented");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(res))
    else $error("stalled result word lost or changed");

endmodule

// ===== bench/keyboard_packet_decoder_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_packet_decoder_top_test
// Self-checking bench for the keyboard packet decoder. A short directed run
// covers headers, headers taken as packet data, mouse deltas at the extremes
// and every cursor make and break code. Random packet streams follow, with
// the mouse drifting so the position accumulators wrap. Every result word is
// checked field by field against a local model of the parser. Both channels
// idle at random in the first two of three phases of differing pressure.
// ----------------------------------------------------------------------------
module keyboard_packet_decoder_top_test;
  import kpd_pkg::*;

  localparam int N_RANDOM     = 1400;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 10;   // comfortably past the pipeline latency

  // Parser phases of the local model
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_JOY0,
    PH_JOY1,
    PH_DX,
    PH_DY
  } parse_phase_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup. Every DUT input is known from time zero.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [7:0]         in_scan_byte = 8'h00;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [7:0]         out_joystick0;
  logic [7:0]         out_joystick1;
  logic [7:0]         out_cursor_joystick;
  logic signed [15:0] out_mouse_x;
  logic signed [15:0] out_mouse_y;
  logic [1:0]         out_mouse_buttons;
  logic [7:0]         out_recent_key;

  keyboard_packet_decoder_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_scan_byte        (in_scan_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_joystick0       (out_joystick0),
    .out_joystick1       (out_joystick1),
    .out_cursor_joystick (out_cursor_joystick),
    .out_mouse_x         (out_mouse_x),
    .out_mouse_y         (out_mouse_y),
    .out_mouse_buttons   (out_mouse_buttons),
    .out_recent_key      (out_recent_key)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic [7:0]  scan_q[$];      // bytes still to be sent
  kpd_result_t decoded_q[$];   // expected result words, oldest first
  int          accepted   = 0; // bytes taken by the DUT so far
  int          mismatches = 0;
  int          phase1_end = 0;
  int          phase2_end = 0;

  // Local copy of the parser state; reset values are all zero / idle
  parse_phase_t parse_phase = PH_IDLE;
  logic [7:0]   joy0_q      = 8'h00;
  logic [7:0]   joy1_q      = 8'h00;
  logic [7:0]   cursor_q    = 8'h00;
  logic [15:0]  pos_x_q     = 16'h0000;
  logic [15:0]  pos_y_q     = 16'h0000;
  logic [1:0]   buttons_q   = 2'b00;
  logic [7:0]   key_q       = 8'h00;

  // Idle pressure, stepped on the number of bytes accepted:
  // sender 16 / receiver 45, then swapped, then no idling at all.
  function automatic int sender_gap_pct();
    if (accepted < phase1_end) return 16;
    if (accepted < phase2_end) return 45;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (accepted < phase1_end) return 45;
    if (accepted < phase2_end) return 16;
    return 0;
  endfunction

  // Joystick bit driven by a cursor make code; zero for any other byte
  function automatic logic [7:0] cursor_mask(input logic [7:0] code);
    if (code == KEY_UP)    return CJ_UP;
    if (code == KEY_DOWN)  return CJ_DOWN;
    if (code == KEY_LEFT)  return CJ_LEFT;
    if (code == KEY_RIGHT) return CJ_RIGHT;
    if (code == KEY_SPACE) return CJ_FIRE;
    return 8'h00;
  endfunction

  // Advance the model by one accepted byte and queue the word it must produce
  task automatic decode_byte(input logic [7:0] b);
    kpd_result_t word;
    logic [7:0]  make_bit;
    logic [7:0]  break_bit;
    make_bit  = cursor_mask(b);
    break_bit = cursor_mask({1'b0, b[6:0]});
    case (parse_phase)
      PH_JOY1: begin
        joy1_q      = b;
        parse_phase = PH_IDLE;
      end
      PH_JOY0: begin
        joy0_q      = b;
        parse_phase = PH_IDLE;
      end
      PH_DX: begin
        pos_x_q     = pos_x_q + {{8{b[7]}}, b};
        parse_phase = PH_DY;
      end
      PH_DY: begin
        pos_y_q     = pos_y_q + {{8{b[7]}}, b};
        parse_phase = PH_IDLE;
      end
      default: begin
        // idle: headers open a packet, anything else is decoded on its own
        parse_phase = PH_IDLE;
        if (b == HDR_JOY1) begin
          parse_phase = PH_JOY1;
        end else if (b == HDR_JOY0) begin
          parse_phase = PH_JOY0;
        end else if (b >= HDR_MOUSE_LO && b <= HDR_MOUSE_HI) begin
          buttons_q   = b[1:0];
          parse_phase = PH_DX;
        end else if (make_bit != 8'h00) begin
          cursor_q = cursor_q | make_bit;
        end else if (b[7] && break_bit != 8'h00) begin
          cursor_q = cursor_q & ~break_bit;
        end else begin
          key_q = b;
        end
      end
    endcase
    word.joystick0       = joy0_q;
    word.joystick1       = joy1_q;
    word.cursor_joystick = cursor_q;
    word.mouse_x         = pos_x_q;
    word.mouse_y         = pos_y_q;
    word.mouse_buttons   = buttons_q;
    word.recent_key      = key_q;
    decoded_q.push_back(word);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 'h%h, got 'h%h", $time, name, exp_v, act_v);
    end
  endtask

  // Packet data byte, leaning on the extremes and on header values
  function automatic logic [7:0] packet_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'($urandom_range(8'hFF, 8'hF8));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mouse delta with a steady drift so the accumulator wraps within the run
  function automatic logic [7:0] drift_delta(input bit upward);
    if ($urandom_range(99) < 85) return upward ? 8'h7F : 8'h80;
    return packet_byte();
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued bytes, holds a stalled word, updates the model on
  // each acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_scan_byte);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (scan_q.size() > 0 && $urandom_range(99) >= sender_gap_pct()) begin
          in_valid     <= 1'b1;
          in_scan_byte <= scan_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result word against the oldest expectation
  // and stalls the result channel at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    kpd_result_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, recent_key 'h%h", $time,
                 out_recent_key);
      end else begin
        exp_w = decoded_q.pop_front();
        check_field("joystick0", 16'(exp_w.joystick0), 16'(out_joystick0));
        check_field("joystick1", 16'(exp_w.joystick1), 16'(out_joystick1));
        check_field("cursor_joystick", 16'(exp_w.cursor_joystick),
                    16'(out_cursor_joystick));
        check_field("mouse_x", exp_w.mouse_x, out_mouse_x);
        check_field("mouse_y", exp_w.mouse_y, out_mouse_y);
        check_field("mouse_buttons", 16'(exp_w.mouse_buttons), 16'(out_mouse_buttons));
        check_field("recent_key", 16'(exp_w.recent_key), 16'(out_recent_key));
      end
    end
    out_stall <= ($urandom_range(99) < receiver_stall_pct());
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hung handshake ends the run as a failure.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL keyboard_packet_decoder_top");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int   target;
    int   total;
    int   kind;
    bit   x_up;
    bit   y_up;
    logic [7:0] code;

    // Directed: plain key 0, headers taken as joystick data, mouse deltas at
    // both extremes (button bits 3 then 0), headers as mouse data, all five
    // cursor make codes then their break codes, and non-cursor high bytes
    // that must land in the recent key.
    scan_q = '{8'h00,
               HDR_JOY1, HDR_JOY0,
               HDR_JOY0, HDR_JOY1,
               HDR_MOUSE_HI, 8'h7F, 8'h80,
               HDR_MOUSE_LO, 8'hF9, 8'hFE,
               KEY_UP, KEY_LEFT, KEY_RIGHT, KEY_DOWN, KEY_SPACE,
               KEY_UP | 8'h80, KEY_LEFT | 8'h80, KEY_RIGHT | 8'h80,
               KEY_DOWN | 8'h80, KEY_SPACE | 8'h80,
               8'hF7, 8'h80};

    // Random: mostly whole packets with random content; the rest is cursor
    // traffic and arbitrary bytes (which may themselves open a packet).
    x_up   = 1'($urandom_range(1));
    y_up   = 1'($urandom_range(1));
    target = scan_q.size() + N_RANDOM;
    while (scan_q.size() < target) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        scan_q.push_back(8'($urandom_range(8'hFB, 8'hF8)));
        scan_q.push_back(drift_delta(x_up));
        scan_q.push_back(drift_delta(y_up));
      end else if (kind < 70) begin
        scan_q.push_back($urandom_range(1) ? HDR_JOY1 : HDR_JOY0);
        scan_q.push_back(packet_byte());
      end else if (kind < 85) begin
        case ($urandom_range(4))
          0:       code = KEY_UP;
          1:       code = KEY_DOWN;
          2:       code = KEY_LEFT;
          3:       code = KEY_RIGHT;
          default: code = KEY_SPACE;
        endcase
        scan_q.push_back($urandom_range(1) ? code : (code | 8'h80));
      end else begin
        scan_q.push_back(8'($urandom_range(255)));
      end
    end

    total      = scan_q.size();
    phase1_end = scan_q.size() / 3;
    phase2_end = 2 * scan_q.size() / 3;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to go in and every word to come back
    while (accepted < total || decoded_q.size() != 0)
      @(posedge clk);
    // Catch any stray word after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (decoded_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d result words never arrived", $time, decoded_q.size());
    end

    if (mismatches == 0) begin
      $display("PASS keyboard_packet_decoder_top");
    end else begin
      $display("FAIL keyboard_packet_decoder_top");
    end
    $finish;
  end

endmodule
